// ===== sv/b32g_pkg.sv =====
// Shared types, constants and the character lookup for the base32 encoder
// with dot grouping. Used by the top level and by the output sequencer.
// No dependencies.
`timescale 1ns / 1ps

package b32g_pkg;

	localparam int SYM_W     = 5;
	localparam int CHAR_W    = 8;
	localparam int MAX_CHARS = 3;

	localparam logic [CHAR_W-1:0] DOT_CHAR         = 8'h2E;
	localparam logic [7:0]        GROUP_SIZE_RESET = 8'd32;

	// One encoded input byte: up to three 5-bit symbols, how many are valid
	// and whether they close the message.
	typedef struct packed {
		logic [MAX_CHARS-1:0][SYM_W-1:0] syms;
		logic [1:0]                      nchar;
		logic                            last;
	} b32g_item_t;

	// Base32 alphabet: A..Z for 0..25, then 2..7 for 26..31.
	function automatic logic [CHAR_W-1:0] b32_char(input logic [SYM_W-1:0] sym);
		logic [SYM_W-1:0] ofs;
		ofs = sym - 5'd26;
		if (sym < 5'd26) begin
			return 8'h41 + {3'b000, sym};
		end else begin
			return 8'h32 + {3'b000, ofs};
		end
	endfunction

endpackage

// ===== sv/b32g_emit.sv =====
// Output sequencer: walks the symbols of one encoded byte, inserts dots and
// drives the registered result channel. Depends on b32g_pkg.
`timescale 1ns / 1ps

module b32g_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   group_size,
	input  logic                         item_valid,
	input  b32g_pkg::b32g_item_t         item,
	output logic                         item_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [b32g_pkg::CHAR_W-1:0]  out_char,
	output logic                         out_last
);

	logic [1:0] k_q;
	logic [7:0] idx_q;
	logic       any_q;
	logic       out_valid_q;
	logic [b32g_pkg::CHAR_W-1:0] out_char_q;
	logic       out_last_q;

	logic                        fire;
	logic                        need_dot;
	logic                        final_char;
	logic [b32g_pkg::SYM_W-1:0]  cur_sym;
	logic [7:0]                  idx_inc;

	assign fire       = item_valid && (!out_valid_q || out_ready);
	assign need_dot   = (group_size != 8'd0) && any_q && (idx_q >= group_size);
	assign final_char = (k_q == (item.nchar - 2'd1));
	assign cur_sym    = item.syms[k_q];
	assign idx_inc    = (idx_q == 8'hFF) ? idx_q : idx_q + 8'd1;
	assign item_take  = fire && !need_dot && final_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 2'd0;
			idx_q       <= 8'd0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				if (need_dot) begin
					idx_q <= 8'd0;
				end else if (final_char) begin
					k_q <= 2'd0;
					if (item.last) begin
						idx_q <= 8'd0;
						any_q <= 1'b0;
					end else begin
						idx_q <= idx_inc;
						any_q <= 1'b1;
					end
				end else begin
					k_q   <= k_q + 2'd1;
					idx_q <= idx_inc;
					any_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload carries no reset.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (need_dot) begin
				out_char_q <= b32g_pkg::DOT_CHAR;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= b32g_pkg::b32_char(cur_sym);
				out_last_q <= item.last && final_char;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	a_idle_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid |-> (k_q == 2'd0))
		else $error("symbol pointer not at zero while no item is held");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> (k_q < item.nchar))
		else $error("symbol pointer beyond the item's symbol count");

	a_fresh_msg: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (idx_q == 8'd0))
		else $error("character count nonzero at message start");

	a_last_not_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_char_q != b32g_pkg::DOT_CHAR))
		else $error("dot marked as the final character");

endmodule

// ===== sv/base32_encoder_with_dot_grouping_unit.sv =====
// Top level of the base32 encoder with dot grouping: bit buffer, symbol
// extraction and the item register. Depends on b32g_pkg and b32g_emit.
`timescale 1ns / 1ps

// Channel   Signals                                         Transfer when
// -------   ---------------------------------------------   -----------------------
// input     in_valid, in_ready, in_byte, in_last             in_valid && in_ready
// output    out_valid, out_ready, out_char, out_last         out_valid && out_ready
// config    cfg_wr_en, cfg_wr_data (group_size)              cfg_wr_en
//
// Each input byte produces one to three characters, each possibly preceded by a
// dot, so one to six results; the single output port moves one result a cycle
// while out_ready holds high. The first result of a byte is registered in the item
// register and then in the output register after its input transfer.
// A new byte is taken while the previous one drains, as soon as its last result
// is loaded into the output register. Reset clears the bit buffer, the counters
// and both valid flags and loads group_size with 32. Output stalls back up into
// the item register and then into in_ready.

module base32_encoder_with_dot_grouping_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	// Configuration register.
	logic [7:0] group_size_q;

	// Bit buffer: up to four bits not yet encoded, right aligned.
	logic [3:0] lb_q;
	logic [2:0] cnt_q;

	// Item register between symbol extraction and the output sequencer.
	logic                  item_valid_s1;
	b32g_pkg::b32g_item_t  item_s1;

	logic                  item_take;
	logic                  in_fire;
	logic [11:0]           acc;
	logic [16:0]           win;
	logic [3:0]            nbits;
	logic                  two_full;
	logic [2:0]            rem;
	logic [11:0]           rem_mask;
	b32g_pkg::b32g_item_t  item_d;

	assign in_ready = !item_valid_s1 || item_take;
	assign in_fire  = in_valid && in_ready;

	// The buffer bits sit above the new byte; the window adds five zero bits
	// below so that the padded final character falls out of the same shift.
	assign acc      = {lb_q, in_byte};
	assign win      = {acc, 5'b00000};
	assign nbits    = {1'b0, cnt_q} + 4'd8;
	assign two_full = (nbits >= 4'd10);
	assign rem      = two_full ? 3'(nbits - 4'd10) : 3'(nbits - 4'd5);
	assign rem_mask = (12'd1 << rem) - 12'd1;

	always_comb begin
		item_d.syms[0] = 5'(win >> nbits);
		item_d.syms[1] = 5'(win >> (nbits - 4'd5));
		item_d.syms[2] = 5'(win >> (nbits - 4'd10));
		item_d.nchar   = (two_full ? 2'd2 : 2'd1)
		               + {1'b0, (in_last && (rem != 3'd0))};
		item_d.last    = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q  <= b32g_pkg::GROUP_SIZE_RESET;
			lb_q          <= 4'd0;
			cnt_q         <= 3'd0;
			item_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				group_size_q <= cfg_wr_data;
			end
			if (in_fire) begin
				item_valid_s1 <= 1'b1;
				if (in_last) begin
					lb_q  <= 4'd0;
					cnt_q <= 3'd0;
				end else begin
					lb_q  <= 4'(acc & rem_mask);
					cnt_q <= rem;
				end
			end else if (item_take) begin
				item_valid_s1 <= 1'b0;
			end
		end
	end

	// The item payload needs no reset; it is only looked at while valid.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_d;
		end
	end

	// The sequencer owns the dot count and the result register.
	b32g_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.group_size (group_size_q),
		.item_valid (item_valid_s1),
		.item       (item_s1),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.out_last   (out_last)
	);

endmodule
